/* hdl/lumi_pkg.sv */
// ----------------------------------------------------------------------------
// lumi_pkg
// shared types, constants and helpers of the lu matrix inverse unit
// ----------------------------------------------------------------------------
package lumi_pkg;

    localparam int DEF_MAX_ORDER = 8;
    localparam int DEF_FRAC_BITS = 16;

    localparam int VAL_W = 32;
    localparam int ORDER_REG_W = 4;
    localparam int THRESH_W = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_ORDER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESH = 1'b1;

    localparam logic [ORDER_REG_W-1:0] ORDER_RESET = 4'd2;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    // one loaded element on its way from the front to the back
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_load_item;

    // request to the divider
    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] num;
        logic signed [VAL_W-1:0] den;
    } t_div_req;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            r = VAL_MAX;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = VAL_MIN;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/lumi_front.sv */
// ----------------------------------------------------------------------------
// lumi_front
// accepts matrix elements, counts them and marks the last one of a matrix
// ----------------------------------------------------------------------------
module lumi_front #(
    parameter int MAX_ORDER = lumi_pkg::DEF_MAX_ORDER
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_ORDER+1)-1:0] i_order,
    input  logic                          i_cfg_clr,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output lumi_pkg::t_load_item          o_q_item
);
    import lumi_pkg::*;

    localparam int CW = $clog2(MAX_ORDER * MAX_ORDER + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] total;
    logic          is_last;

    assign total = CW'(i_order * i_order);
    assign is_last = (CW'(r_cnt + 1'b1) == total);
    assign s_axis_tready = !i_q_full;
    assign o_q_push = s_axis_tvalid && !i_q_full;
    assign o_q_item.value = s_axis_tdata;
    assign o_q_item.last = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_clr) begin
            r_cnt <= '0;
        end else if (o_q_push) begin
            r_cnt <= is_last ? '0 : CW'(r_cnt + 1'b1);
        end
    end

endmodule

/* hdl/lumi_queue.sv */
// ----------------------------------------------------------------------------
// lumi_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module lumi_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lumi_pkg::t_load_item i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output lumi_pkg::t_load_item o_item
);
    import lumi_pkg::*;

    t_load_item r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_full = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

/* hdl/lumi_div.sv */
// ----------------------------------------------------------------------------
// lumi_div
// radix-2 restoring fixed-point divider, truncating and saturating
// ----------------------------------------------------------------------------
module lumi_div #(
    parameter int FRAC_BITS = lumi_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lumi_pkg::t_div_req  i_req,
    output logic                o_done,
    output logic signed [31:0]  o_quot
);
    import lumi_pkg::*;

    localparam int NW = VAL_W + FRAC_BITS;
    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0]    r_num;
    logic [VAL_W-1:0] r_den;
    logic [VAL_W-1:0] r_rem;
    logic             r_neg;
    logic             r_aneg;
    logic             r_bz;
    logic             r_busy;
    logic             r_done;
    logic [KW-1:0]    r_cnt;

    logic [VAL_W-1:0] a_mag;
    logic [VAL_W-1:0] b_mag;
    logic [VAL_W:0]   trial;
    logic             fits;

    assign a_mag = i_req.num[VAL_W-1] ? VAL_W'(-i_req.num) : i_req.num;
    assign b_mag = i_req.den[VAL_W-1] ? VAL_W'(-i_req.den) : i_req.den;
    assign trial = {r_rem, r_num[NW-1]};
    assign fits = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= {a_mag, {FRAC_BITS{1'b0}}};
            r_den <= b_mag;
            r_rem <= '0;
            r_neg <= i_req.num[VAL_W-1] ^ i_req.den[VAL_W-1];
            r_aneg <= i_req.num[VAL_W-1];
            r_bz <= (i_req.den == '0);
        end else if (r_busy) begin
            r_rem <= fits ? VAL_W'(trial - {1'b0, r_den}) : trial[VAL_W-1:0];
            r_num <= {r_num[NW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == KW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= KW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // sign and saturation of the finished quotient magnitude
    always_comb begin
        if (r_bz) begin
            o_quot = r_aneg ? VAL_MIN : VAL_MAX;
        end else if (r_neg) begin
            o_quot = (r_num > NW'(33'h0_8000_0000)) ? VAL_MIN : VAL_W'(-r_num);
        end else begin
            o_quot = (r_num > NW'(33'h0_7fff_ffff)) ? VAL_MAX : r_num[VAL_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

/* hdl/lumi_back.sv */
// ----------------------------------------------------------------------------
// lumi_back
// stores the matrix, factors it, solves for the inverse and streams it out
// ----------------------------------------------------------------------------
module lumi_back #(
    parameter int MAX_ORDER = lumi_pkg::DEF_MAX_ORDER,
    parameter int FRAC_BITS = lumi_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(MAX_ORDER+1)-1:0] i_order,
    input  logic [30:0]                    i_thresh,
    input  logic                           i_cfg_clr,
    input  logic                           i_q_valid,
    input  lumi_pkg::t_load_item           i_q_item,
    output logic                           o_q_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import lumi_pkg::*;

    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int AW = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam logic signed [VAL_W-1:0] ONE = VAL_W'(64'd1 << FRAC_BITS);

    localparam logic [4:0] S_LOAD    = 5'd0;
    localparam logic [4:0] S_PIV_RD  = 5'd1;
    localparam logic [4:0] S_PIV_CHK = 5'd2;
    localparam logic [4:0] S_DIVL_RD = 5'd3;
    localparam logic [4:0] S_DIVL_GO = 5'd4;
    localparam logic [4:0] S_DIVL_WT = 5'd5;
    localparam logic [4:0] S_UPD_RD1 = 5'd6;
    localparam logic [4:0] S_UPD_RD2 = 5'd7;
    localparam logic [4:0] S_UPD_RD3 = 5'd8;
    localparam logic [4:0] S_UPD_MQ  = 5'd9;
    localparam logic [4:0] S_UPD_WR  = 5'd10;
    localparam logic [4:0] S_NEXTK   = 5'd11;
    localparam logic [4:0] S_INIT    = 5'd12;
    localparam logic [4:0] S_FW_ST   = 5'd13;
    localparam logic [4:0] S_FW_RD   = 5'd14;
    localparam logic [4:0] S_FW_MUL  = 5'd15;
    localparam logic [4:0] S_FW_ACC  = 5'd16;
    localparam logic [4:0] S_FW_WR   = 5'd17;
    localparam logic [4:0] S_BK_ST   = 5'd18;
    localparam logic [4:0] S_BK_RD   = 5'd19;
    localparam logic [4:0] S_BK_MUL  = 5'd20;
    localparam logic [4:0] S_BK_ACC  = 5'd21;
    localparam logic [4:0] S_BK_SUB  = 5'd22;
    localparam logic [4:0] S_BK_DIV  = 5'd23;
    localparam logic [4:0] S_BK_WT   = 5'd24;
    localparam logic [4:0] S_OUT_RD  = 5'd25;
    localparam logic [4:0] S_OUT     = 5'd26;
    localparam logic [4:0] S_SING    = 5'd27;

    function automatic logic [AW-1:0] adr(input logic [OW-1:0] r, input logic [OW-1:0] c);
        logic [AW-1:0] a;
        a = {r[IW-1:0], c[IW-1:0]};
        return a;
    endfunction

    // product shifted down with truncation toward zero, then saturated
    function automatic logic signed [VAL_W-1:0] mul_fin(input logic signed [63:0] p);
        logic signed [63:0] sh;
        sh = p >>> FRAC_BITS;
        if (p[63] && (p[FRAC_BITS-1:0] != '0)) begin
            sh = sh + 64'sd1;
        end
        return sat32(sh);
    endfunction

    logic signed [VAL_W-1:0] r_lmem [DEPTH];
    logic signed [VAL_W-1:0] r_xmem [DEPTH];
    logic signed [VAL_W-1:0] r_lrd;
    logic signed [VAL_W-1:0] r_xrd;

    logic [4:0]              r_state;
    logic [OW-1:0]           r_k;
    logic [OW-1:0]           r_i;
    logic [OW-1:0]           r_j;
    logic [OW-1:0]           r_c;
    logic [OW-1:0]           r_li;
    logic [OW-1:0]           r_lj;
    logic signed [VAL_W-1:0] r_piv;
    logic signed [VAL_W-1:0] r_a;
    logic signed [63:0]      r_prod;
    logic signed [VAL_W-1:0] r_mq;
    logic signed [VAL_W-1:0] r_s;
    logic signed [VAL_W-1:0] r_t;
    logic                    r_ov;
    logic [VAL_W-1:0]        r_odata;
    logic                    r_osing;
    logic                    r_olast;

    logic [AW-1:0]           l_raddr;
    logic [AW-1:0]           x_raddr;
    logic                    l_we;
    logic [AW-1:0]           l_waddr;
    logic signed [VAL_W-1:0] l_wdata;
    logic                    x_we;
    logic [AW-1:0]           x_waddr;
    logic signed [VAL_W-1:0] x_wdata;
    logic                    out_free;
    logic                    piv_small;
    logic [VAL_W:0]          piv_mag;
    t_div_req                div_req;
    logic                    div_done;
    logic signed [VAL_W-1:0] div_q;
    logic [OW-1:0]           n_max;

    assign n_max = OW'(i_order - 1'b1);
    assign out_free = !r_ov || m_axis_tready;
    assign o_q_pop = (r_state == S_LOAD) && i_q_valid;
    assign piv_mag = r_lrd[VAL_W-1] ? (VAL_W+1)'(-{r_lrd[VAL_W-1], r_lrd})
                                    : {1'b0, r_lrd};
    assign piv_small = (piv_mag < {2'b00, i_thresh});

    lumi_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_q)
    );

    always_comb begin
        div_req.start = 1'b0;
        div_req.num = r_lrd;
        div_req.den = r_piv;
        if (r_state == S_DIVL_GO) begin
            div_req.start = 1'b1;
        end else if (r_state == S_BK_DIV) begin
            div_req.start = 1'b1;
            div_req.num = r_t;
            div_req.den = r_lrd;
        end
    end

    // read addresses
    always_comb begin
        l_raddr = adr(r_i, r_j);
        x_raddr = adr(r_i, r_c);
        case (r_state)
            S_PIV_RD:             l_raddr = adr(r_k, r_k);
            S_DIVL_RD, S_UPD_RD1: l_raddr = adr(r_i, r_k);
            S_UPD_RD2:            l_raddr = adr(r_k, r_j);
            S_BK_SUB:             l_raddr = adr(r_i, r_i);
            default:              l_raddr = adr(r_i, r_j);
        endcase
        case (r_state)
            S_FW_RD:         x_raddr = (r_j < r_i) ? adr(r_j, r_c) : adr(r_i, r_c);
            S_BK_RD:         x_raddr = (r_j < i_order) ? adr(r_j, r_c) : adr(r_i, r_c);
            S_OUT_RD, S_OUT: x_raddr = adr(r_i, r_j);
            default:         x_raddr = adr(r_i, r_c);
        endcase
    end

    // write ports
    always_comb begin
        l_we = 1'b0;
        l_waddr = adr(r_i, r_j);
        l_wdata = sat32(64'(r_lrd) - 64'(r_mq));
        x_we = 1'b0;
        x_waddr = adr(r_i, r_c);
        x_wdata = div_q;
        case (r_state)
            S_LOAD: begin
                l_we = i_q_valid;
                l_waddr = adr(r_li, r_lj);
                l_wdata = i_q_item.value;
            end
            S_DIVL_WT: begin
                l_we = div_done;
                l_waddr = adr(r_i, r_k);
                l_wdata = div_q;
            end
            S_UPD_WR: begin
                l_we = 1'b1;
            end
            S_INIT: begin
                x_we = 1'b1;
                x_waddr = adr(r_i, r_j);
                x_wdata = (r_i == r_j) ? ONE : '0;
            end
            S_FW_WR: begin
                x_we = 1'b1;
                x_wdata = sat32(64'(r_xrd) - 64'(r_s));
            end
            S_BK_WT: begin
                x_we = div_done;
            end
            default: begin
                l_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_lmem[l_waddr] <= l_wdata;
        end
        r_lrd <= r_lmem[l_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            r_xmem[x_waddr] <= x_wdata;
        end
        r_xrd <= r_xmem[x_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_li <= '0;
            r_lj <= '0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_cfg_clr) begin
                        r_li <= '0;
                        r_lj <= '0;
                    end else if (i_q_valid) begin
                        if (i_q_item.last) begin
                            r_li <= '0;
                            r_lj <= '0;
                            r_k <= '0;
                            r_state <= S_PIV_RD;
                        end else if (r_lj == n_max) begin
                            r_lj <= '0;
                            r_li <= OW'(r_li + 1'b1);
                        end else begin
                            r_lj <= OW'(r_lj + 1'b1);
                        end
                    end
                end
                S_PIV_RD: r_state <= S_PIV_CHK;
                S_PIV_CHK: begin
                    r_piv <= r_lrd;
                    r_i <= OW'(r_k + 1'b1);
                    r_j <= OW'(r_k + 1'b1);
                    if (piv_small) begin
                        r_state <= S_SING;
                    end else if (r_k == n_max) begin
                        r_state <= S_NEXTK;
                    end else begin
                        r_state <= S_DIVL_RD;
                    end
                end
                S_DIVL_RD: r_state <= S_DIVL_GO;
                S_DIVL_GO: r_state <= S_DIVL_WT;
                S_DIVL_WT: begin
                    if (div_done) begin
                        if (r_i == n_max) begin
                            r_i <= OW'(r_k + 1'b1);
                            r_state <= S_UPD_RD1;
                        end else begin
                            r_i <= OW'(r_i + 1'b1);
                            r_state <= S_DIVL_RD;
                        end
                    end
                end
                S_UPD_RD1: r_state <= S_UPD_RD2;
                S_UPD_RD2: begin
                    r_a <= r_lrd;
                    r_state <= S_UPD_RD3;
                end
                S_UPD_RD3: begin
                    r_prod <= 64'(r_a) * 64'(r_lrd);
                    r_state <= S_UPD_MQ;
                end
                S_UPD_MQ: begin
                    r_mq <= mul_fin(r_prod);
                    r_state <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    r_state <= S_UPD_RD1;
                    if (r_j == n_max) begin
                        r_j <= OW'(r_k + 1'b1);
                        if (r_i == n_max) begin
                            r_state <= S_NEXTK;
                        end else begin
                            r_i <= OW'(r_i + 1'b1);
                        end
                    end else begin
                        r_j <= OW'(r_j + 1'b1);
                    end
                end
                S_NEXTK: begin
                    r_i <= '0;
                    r_j <= '0;
                    if (r_k == n_max) begin
                        r_state <= S_INIT;
                    end else begin
                        r_k <= OW'(r_k + 1'b1);
                        r_state <= S_PIV_RD;
                    end
                end
                S_INIT: begin
                    if (r_j == n_max) begin
                        r_j <= '0;
                        if (r_i == n_max) begin
                            r_c <= '0;
                            r_i <= OW'(1);
                            r_state <= S_FW_ST;
                        end else begin
                            r_i <= OW'(r_i + 1'b1);
                        end
                    end else begin
                        r_j <= OW'(r_j + 1'b1);
                    end
                end
                S_FW_ST: begin
                    r_s <= '0;
                    r_j <= '0;
                    if (r_i < i_order) begin
                        r_state <= S_FW_RD;
                    end else begin
                        r_i <= n_max;
                        r_state <= S_BK_ST;
                    end
                end
                S_FW_RD: r_state <= (r_j < r_i) ? S_FW_MUL : S_FW_WR;
                S_FW_MUL: begin
                    r_prod <= 64'(r_lrd) * 64'(r_xrd);
                    r_state <= S_FW_ACC;
                end
                S_FW_ACC: begin
                    r_s <= sat32(64'(r_s) + 64'(mul_fin(r_prod)));
                    r_j <= OW'(r_j + 1'b1);
                    r_state <= S_FW_RD;
                end
                S_FW_WR: begin
                    r_i <= OW'(r_i + 1'b1);
                    r_state <= S_FW_ST;
                end
                S_BK_ST: begin
                    r_s <= '0;
                    r_j <= OW'(r_i + 1'b1);
                    r_state <= S_BK_RD;
                end
                S_BK_RD: r_state <= (r_j < i_order) ? S_BK_MUL : S_BK_SUB;
                S_BK_MUL: begin
                    r_prod <= 64'(r_lrd) * 64'(r_xrd);
                    r_state <= S_BK_ACC;
                end
                S_BK_ACC: begin
                    r_s <= sat32(64'(r_s) + 64'(mul_fin(r_prod)));
                    r_j <= OW'(r_j + 1'b1);
                    r_state <= S_BK_RD;
                end
                S_BK_SUB: begin
                    r_t <= sat32(64'(r_xrd) - 64'(r_s));
                    r_state <= S_BK_DIV;
                end
                S_BK_DIV: r_state <= S_BK_WT;
                S_BK_WT: begin
                    if (div_done) begin
                        if (r_i == '0) begin
                            if (r_c == n_max) begin
                                r_i <= '0;
                                r_j <= '0;
                                r_state <= S_OUT_RD;
                            end else begin
                                r_c <= OW'(r_c + 1'b1);
                                r_i <= OW'(1);
                                r_state <= S_FW_ST;
                            end
                        end else begin
                            r_i <= OW'(r_i - 1'b1);
                            r_state <= S_BK_ST;
                        end
                    end
                end
                S_OUT_RD: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_odata <= r_xrd;
                        r_osing <= 1'b0;
                        r_olast <= (r_i == n_max) && (r_j == n_max);
                        r_state <= S_OUT_RD;
                        if (r_j == n_max) begin
                            r_j <= '0;
                            if (r_i == n_max) begin
                                r_state <= S_LOAD;
                            end else begin
                                r_i <= OW'(r_i + 1'b1);
                            end
                        end else begin
                            r_j <= OW'(r_j + 1'b1);
                        end
                    end
                end
                S_SING: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_odata <= '0;
                        r_osing <= 1'b1;
                        r_olast <= 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_osing;
    assign m_axis_tlast = r_olast;

endmodule

/* hdl/lu_matrix_inverse_unit.sv */
// ----------------------------------------------------------------------------
// lu_matrix_inverse_unit
// fixed-point matrix inverse by doolittle lu factorization, no pivoting
// ----------------------------------------------------------------------------
// usage
//   the slave stream takes the n x n elements of a matrix in row-major order,
//   one per transfer, signed fixed point with FRAC_BITS fraction bits
//   the master stream gives the n*n inverse elements in row-major order,
//   tlast on the final one; a pivot below the threshold gives instead one
//   transfer with tdata zero, tuser (singular) high and tlast high
//   the config port sets the order (index 0) and the pivot threshold
//   (index 1); an order write restarts loading at element zero
// timing
//   loading takes one element per cycle while the queue has room; the back
//   end drains the two-entry queue into the matrix memory at one element
//   per cycle while loading; after the last element the sequencer works one
//   memory access at a time through factorization updates, substitution
//   multiply-accumulates (about order^3 steps in all) and divisions, one at
//   a time in the serial divider (order*(order-1)/2 + order^2 of them); the
//   inverse then leaves element by element, each read and then registered
// reset and stalls
//   reset empties the queue, the load counters and the output register,
//   and restores order 2 and threshold 1
//   a stalled receiver holds the output register; the sequencer waits and
//   the front keeps taking elements until the queue is full
module lu_matrix_inverse_unit #(
    parameter int MAX_ORDER = lumi_pkg::DEF_MAX_ORDER,
    parameter int FRAC_BITS = lumi_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [lumi_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lumi_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // element stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,   // [31:0] elem_value
    // inverse stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,   // [31:0] inv_value
    output logic                                m_axis_tuser,   // [0] singular
    output logic                                m_axis_tlast
);
    import lumi_pkg::*;

    localparam int OW = $clog2(MAX_ORDER + 1);

    logic [ORDER_REG_W-1:0] r_order;
    logic [THRESH_W-1:0]    r_thresh;
    logic [OW-1:0]          order_eff;
    logic                   cfg_clr;
    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_valid;
    t_load_item             q_in;
    t_load_item             q_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ORDER:  r_order <= i_cfg_data[ORDER_REG_W-1:0];
                REG_THRESH: r_thresh <= i_cfg_data[THRESH_W-1:0];
                default:    r_order <= r_order;
            endcase
        end
    end

    assign cfg_clr = i_cfg_we && (i_cfg_index == REG_ORDER);

    // order zero acts as one, above the maximum it clamps
    always_comb begin
        if (r_order == '0) begin
            order_eff = OW'(1);
        end else if (32'(r_order) > MAX_ORDER) begin
            order_eff = OW'(MAX_ORDER);
        end else begin
            order_eff = OW'(r_order);
        end
    end

    lumi_front #(
        .MAX_ORDER(MAX_ORDER)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_order      (order_eff),
        .i_cfg_clr    (cfg_clr),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_item     (q_in)
    );

    lumi_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_item (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_item (q_out)
    );

    lumi_back #(
        .MAX_ORDER(MAX_ORDER),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_order      (order_eff),
        .i_thresh     (r_thresh),
        .i_cfg_clr    (cfg_clr),
        .i_q_valid    (q_valid),
        .i_q_item     (q_out),
        .o_q_pop      (q_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

/* hdl/lumi_checker.sv */
// ----------------------------------------------------------------------------
// lumi_assert
// port-level checks of the lu matrix inverse unit
// ----------------------------------------------------------------------------
module lumi_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // a singular report is marked last
    a_sing_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("singular without last");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("singular with nonzero value");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind lu_matrix_inverse_unit lumi_assert u_lumi_assert (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

/* tb/sv/lumi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lumi_checker
// watches the config port and both streams of the lu matrix inverse unit,
// predicts every inverse element from the loaded matrix and compares it
// ----------------------------------------------------------------------------
module lumi_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lumi_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lumi_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [31:0]                         i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [31:0]                         i_m_tdata,
    input  logic                                i_m_tuser,
    input  logic                                i_m_tlast,
    output int                                  o_fail_count,
    output int                                  o_inv_pending
);
    import lumi_pkg::*;

    localparam int MAXN = DEF_MAX_ORDER;
    localparam int FB = DEF_FRAC_BITS;

    typedef logic signed [VAL_W-1:0] t_fx;

    typedef struct {
        t_fx  value;
        logic singular;
        logic last;
    } t_inv_elem;

    t_inv_elem           inv_q[$];
    logic [3:0]          order_reg;
    logic [THRESH_W-1:0] thresh_reg;
    int                  elem_count;
    t_fx                 mat[MAXN*MAXN];
    t_fx                 sol[MAXN*MAXN];

    function automatic t_fx clamp(input longint v);
        if (v > 64'sd2147483647) return VAL_MAX;
        if (v < -64'sd2147483648) return VAL_MIN;
        return t_fx'(v);
    endfunction

    function automatic t_fx q_add(input t_fx a, input t_fx b);
        return clamp(longint'(a) + longint'(b));
    endfunction

    function automatic t_fx q_sub(input t_fx a, input t_fx b);
        return clamp(longint'(a) - longint'(b));
    endfunction

    // product truncated toward zero
    function automatic t_fx q_mul(input t_fx a, input t_fx b);
        longint p;
        p = longint'(a) * longint'(b);
        if (p < 0) return clamp(-((-p) >>> FB));
        return clamp(p >>> FB);
    endfunction

    function automatic t_fx q_div(input t_fx a, input t_fx b);
        longint num;
        if (b == 0) return (a >= 0) ? VAL_MAX : VAL_MIN;
        num = longint'(a) * (64'sd1 <<< FB);
        return clamp(num / longint'(b));
    endfunction

    function automatic int eff_order();
        if (order_reg < 1) return 1;
        if (order_reg > MAXN) return MAXN;
        return int'(order_reg);
    endfunction

    // factor in place, then solve per identity column; 0 on a small pivot
    function automatic bit lu_invert(input int n);
        t_fx    piv;
        t_fx    acc;
        longint mag;
        for (int k = 0; k < n; k++) begin
            piv = mat[k*n+k];
            mag = longint'(piv);
            if (mag < 0) mag = -mag;
            if (mag < longint'(thresh_reg)) return 0;
            for (int i = k + 1; i < n; i++) mat[i*n+k] = q_div(mat[i*n+k], piv);
            for (int i = k + 1; i < n; i++)
                for (int j = k + 1; j < n; j++)
                    mat[i*n+j] = q_sub(mat[i*n+j], q_mul(mat[i*n+k], mat[k*n+j]));
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                sol[i*n+j] = (i == j) ? t_fx'(1 <<< FB) : '0;
        for (int c = 0; c < n; c++) begin
            for (int i = 1; i < n; i++) begin
                acc = '0;
                for (int j = 0; j < i; j++) acc = q_add(acc, q_mul(mat[i*n+j], sol[j*n+c]));
                sol[i*n+c] = q_sub(sol[i*n+c], acc);
            end
            for (int i = n - 1; i >= 0; i--) begin
                acc = '0;
                for (int j = i + 1; j < n; j++) acc = q_add(acc, q_mul(mat[i*n+j], sol[j*n+c]));
                sol[i*n+c] = q_div(q_sub(sol[i*n+c], acc), mat[i*n+i]);
            end
        end
        return 1;
    endfunction

    function automatic void take_element(input t_fx v);
        int        n;
        t_inv_elem e;
        n = eff_order();
        if (elem_count >= n * n) elem_count = 0;
        mat[elem_count] = v;
        elem_count++;
        if (elem_count < n * n) return;
        elem_count = 0;
        if (!lu_invert(n)) begin
            e.value = '0;
            e.singular = 1'b1;
            e.last = 1'b1;
            inv_q.push_back(e);
        end else begin
            for (int i = 0; i < n * n; i++) begin
                e.value = sol[i];
                e.singular = 1'b0;
                e.last = (i == n * n - 1);
                inv_q.push_back(e);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_inv_elem e;
        if (!i_rst_n) begin
            order_reg <= ORDER_RESET;
            thresh_reg <= THRESH_RESET;
            elem_count = 0;
            inv_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ORDER) begin
                    order_reg <= i_cfg_data[3:0];
                    elem_count = 0;
                end else if (i_cfg_index == REG_THRESH) begin
                    thresh_reg <= i_cfg_data[THRESH_W-1:0];
                end
            end
            if (i_s_tvalid && i_s_tready) take_element(t_fx'(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (inv_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected transfer: data %h user %b last %b",
                                 i_m_tdata, i_m_tuser, i_m_tlast);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = inv_q.pop_front();
                    if (i_m_tdata !== e.value || i_m_tuser !== e.singular
                        || i_m_tlast !== e.last) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                     e.value, e.singular, e.last,
                                     i_m_tdata, i_m_tuser, i_m_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_inv_pending <= inv_q.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the lu matrix inverse unit: directed corner
// matrices, then random orders, thresholds and matrices under random stalls
// ----------------------------------------------------------------------------
module testbench;
    import lumi_pkg::*;

    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int TARGET_ITEMS = 330;
    localparam int SETTLE = 60;
    localparam int ONE = 32'h0001_0000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    int                     fail_count;
    int                     inv_pending;
    bit                     quiet = 1'b0;   // no idling in the last part
    int                     elems_sent = 0;
    longint                 cycles = 0;
    int                     stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lu_matrix_inverse_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
        .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast)
    );

    lumi_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_inv_pending(inv_pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one element transfer, with an optional idle burst ahead of it
    task automatic send_elem(input logic [31:0] v);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(posedge i_clk); while (!s_tready);
        elems_sent++;
    endtask

    // drop valid and let the block drain before touching its registers
    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (inv_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random matrix: mostly diagonally dominant, some noise, some rank deficient
    task automatic send_matrix(input int n);
        int          kind;
        logic [31:0] row0[8];
        logic [31:0] v;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (kind == 9) begin
                    v = $urandom;
                end else if (kind == 8 && i == n - 1 && n > 1) begin
                    v = row0[j];              // repeated row
                end else if (i == j) begin
                    v = (n * 2 + $urandom_range(1, 6)) * ONE + $urandom_range(0, ONE - 1);
                    if ($urandom_range(0, 1)) v = -v;
                end else begin
                    v = $urandom_range(0, 4 * ONE) - 2 * ONE;
                end
                if (i == 0) row0[j] = v;
                send_elem(v);
            end
        end
    endtask

    initial begin
        int n;
        int pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset order 2: identity and a known 2x2
        send_elem(ONE); send_elem(0); send_elem(0); send_elem(ONE);
        send_elem(4 * ONE); send_elem(7 * ONE); send_elem(2 * ONE); send_elem(6 * ONE);
        go_idle();

        // order 0 behaves as 1: extremes and a zero pivot
        write_reg(REG_ORDER, 31'd0);
        send_elem(32'h7fff_ffff); send_elem(32'h8000_0000);
        send_elem(32'h0000_0000); send_elem(32'hffff_ffff); send_elem(32'h0000_0001);
        go_idle();

        // zero threshold: division by a zero pivot saturates both ways
        write_reg(REG_THRESH, 31'd0);
        send_elem(0);
        go_idle();
        write_reg(REG_ORDER, 31'd2);
        send_elem(0); send_elem(ONE); send_elem(-3 * ONE); send_elem(ONE);
        send_elem(0); send_elem(ONE); send_elem(3 * ONE); send_elem(ONE);
        go_idle();

        // largest threshold: only full-scale pivots pass
        write_reg(REG_THRESH, 31'h7fff_ffff);
        send_elem(32'h7fff_ffff); send_elem(0); send_elem(0); send_elem(32'h7fff_ffff);
        go_idle();

        // order rewritten part way through a load discards it
        write_reg(REG_THRESH, 31'd1);
        write_reg(REG_ORDER, 31'd3);
        send_elem(5 * ONE); send_elem(ONE); send_elem(2 * ONE);
        go_idle();
        write_reg(REG_ORDER, 31'd1);
        send_elem(2 * ONE);
        go_idle();

        // random phases, mostly small orders, a few at the top
        while (elems_sent < TARGET_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) n = $urandom_range(9, 15);
            else if (pick == 1) n = 8;
            else if (pick == 2) n = 0;
            else if (pick < 6) n = 4;
            else n = $urandom_range(1, 3);
            write_reg(REG_ORDER, n[30:0]);
            pick = $urandom_range(0, 9);
            if (pick == 0) write_reg(REG_THRESH, 31'd0);
            else if (pick == 1) write_reg(REG_THRESH, 31'($urandom));
            else if (pick < 5) write_reg(REG_THRESH, 31'($urandom_range(1, ONE)));
            if (n < 1) n = 1;
            if (n > 8) n = 8;
            if (elems_sent > TARGET_ITEMS - 60) quiet = 1'b1;
            repeat ($urandom_range(1, 3)) send_matrix(n);
            go_idle();
        end

        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/lumi_pkg.sv
hdl/lumi_front.sv
hdl/lumi_queue.sv
hdl/lumi_div.sv
hdl/lumi_back.sv
hdl/lu_matrix_inverse_unit.sv
hdl/lumi_checker.sv
tb/sv/lumi_checker.sv
tb/sv/testbench.sv
